// File: hdl/sst_pkg.sv
`timescale 1ns / 1ps

package sst_pkg;

	localparam int KIND_W   = 2;
	localparam int LEN_W    = 4;
	localparam int TYPE_W   = 4;
	localparam int DEPTH_W  = 8;
	localparam int STATUS_W = 2;

	localparam logic [KIND_W-1:0] KIND_DEFINE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ENTER  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_EXIT   = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_REDEF     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

	localparam logic [DEPTH_W-1:0] SCOPE_MAX = 8'hFF;

	// Broadcast control from the sequencer to every cell of the stack
	typedef struct packed {
		logic               tok_step;  // advance the search token one cell
		logic               push;      // shift entries one cell deeper
		logic               pop;       // shift entries one cell towards the top
		logic               wr_type;   // overwrite the type of the token cell
		logic               lookup;    // search ignores scope depth
		logic [LEN_W-1:0]   q_len;
		logic [TYPE_W-1:0]  q_type;
		logic [DEPTH_W-1:0] q_depth;
	} cell_ctrl_t;

endpackage

// File: hdl/sst_cell.sv
`timescale 1ns / 1ps

module sst_cell #(
	parameter int KEY_W = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sst_pkg::cell_ctrl_t           ctrl,
	input  logic [KEY_W-1:0]              q_key,
	input  logic                          tok_in,
	input  logic [KEY_W-1:0]              up_key,
	input  logic [sst_pkg::LEN_W-1:0]     up_len,
	input  logic [sst_pkg::TYPE_W-1:0]    up_typ,
	input  logic [sst_pkg::DEPTH_W-1:0]   up_depth,
	input  logic [KEY_W-1:0]              dn_key,
	input  logic [sst_pkg::LEN_W-1:0]     dn_len,
	input  logic [sst_pkg::TYPE_W-1:0]    dn_typ,
	input  logic [sst_pkg::DEPTH_W-1:0]   dn_depth,
	output logic                          tok,
	output logic [KEY_W-1:0]              key,
	output logic [sst_pkg::LEN_W-1:0]     len,
	output logic [sst_pkg::TYPE_W-1:0]    typ,
	output logic [sst_pkg::DEPTH_W-1:0]   depth,
	output logic                          hit,
	output logic                          stop,
	output logic [sst_pkg::TYPE_W-1:0]    hit_typ
);
	import sst_pkg::*;

	logic               tok_q;
	logic [KEY_W-1:0]   key_q;
	logic [LEN_W-1:0]   len_q;
	logic [TYPE_W-1:0]  typ_q;
	logic [DEPTH_W-1:0] depth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= ctrl.tok_step ? tok_in : 1'b0;
		end
	end

	// Entry payload: shift on push and pop, retype in place on overwrite
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			key_q   <= up_key;
			len_q   <= up_len;
			typ_q   <= up_typ;
			depth_q <= up_depth;
		end else if (ctrl.pop) begin
			key_q   <= dn_key;
			len_q   <= dn_len;
			typ_q   <= dn_typ;
			depth_q <= dn_depth;
		end else if (ctrl.wr_type && tok_q) begin
			typ_q <= ctrl.q_type;
		end
	end

	assign hit = tok_q && (len_q == ctrl.q_len) && (key_q == q_key)
		&& (ctrl.lookup || (depth_q == ctrl.q_depth));
	assign stop    = tok_q && !ctrl.lookup && (depth_q < ctrl.q_depth);
	assign hit_typ = hit ? typ_q : '0;

	assign tok   = tok_q;
	assign key   = key_q;
	assign len   = len_q;
	assign typ   = typ_q;
	assign depth = depth_q;

endmodule

// File: hdl/scoped_symbol_table.sv
`timescale 1ns / 1ps

// Scoped symbol table: a stack of (name, length, type, depth) entries held in
// a row of cells, newest entry in the first cell.
// Request channel (req_valid / req_stall): kind, name_key, ident_len, type_code.
// An item is taken on a rising edge with req_valid high and req_stall low;
// req_stall stays high from acceptance until the result has been loaded.
// Response channel (rsp_valid / rsp_stall): status and type_out, exactly one
// item per request, held in an output register until taken.
// Enter scope needs no walk or pop. Define and lookup walk a search token down
// the cell row one cell per cycle; exit scope pops one entry per cycle. The
// next item is taken only after the result has been loaded.
// A stalled response holds its value; the sequencer then waits with the next
// result and keeps req_stall high until the output register frees up.
// Reset empties the table and returns the scope depth to zero; entry contents
// are not cleared, only the entry count.
module scoped_symbol_table #(
	parameter int ENTRIES    = 64,
	parameter int NAME_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [sst_pkg::KIND_W-1:0]    kind,
	input  logic [63:0]                   name_key,
	input  logic [sst_pkg::LEN_W-1:0]     ident_len,
	input  logic [sst_pkg::TYPE_W-1:0]    type_code,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [sst_pkg::STATUS_W-1:0]  status,
	output logic [sst_pkg::TYPE_W-1:0]    type_out
);
	import sst_pkg::*;

	localparam int KEY_W = 8 * NAME_BYTES;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_POP  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    remain_q;
	logic [DEPTH_W-1:0]  scope_q;
	logic [KIND_W-1:0]   op_q;
	logic [KEY_W-1:0]    qkey_q;
	logic [LEN_W-1:0]    qlen_q;
	logic [TYPE_W-1:0]   qtype_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [TYPE_W-1:0]   res_type_q;
	logic                rsp_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [TYPE_W-1:0]   type_out_q;

	cell_ctrl_t ctrl;

	logic [ENTRIES-1:0] tok_v;
	logic [ENTRIES-1:0] hit_v;
	logic [ENTRIES-1:0] stop_v;
	logic [KEY_W-1:0]   key_a   [ENTRIES];
	logic [LEN_W-1:0]   len_a   [ENTRIES];
	logic [TYPE_W-1:0]  typ_a   [ENTRIES];
	logic [DEPTH_W-1:0] depth_a [ENTRIES];
	logic [TYPE_W-1:0]  htyp_a  [ENTRIES];

	logic              start;
	logic              no_more;
	logic              hit_ok;
	logic              stop_ok;
	logic              scan_end;
	logic              full;
	logic [TYPE_W-1:0] hit_type;
	logic              rsp_free;

	assign start   = (state_q == S_IDLE) && req_valid
		&& ((kind == KIND_DEFINE) || (kind == KIND_LOOKUP));
	// The token sits one cell past the live entries once the count runs out
	assign no_more  = (remain_q == '0);
	assign hit_ok   = (|hit_v) && !no_more;
	assign stop_ok  = (|stop_v) && !no_more;
	assign scan_end = no_more || hit_ok || stop_ok;
	assign full     = (count_q == CNT_W'(ENTRIES));
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		hit_type = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_type = hit_type | htyp_a[i];
		end
	end

	always_comb begin
		ctrl          = '0;
		ctrl.lookup   = (op_q == KIND_LOOKUP);
		ctrl.q_len    = qlen_q;
		ctrl.q_type   = qtype_q;
		ctrl.q_depth  = scope_q;
		ctrl.tok_step = start || ((state_q == S_SCAN) && !scan_end);
		ctrl.push     = (state_q == S_SCAN) && (op_q == KIND_DEFINE)
			&& (no_more || stop_ok) && !hit_ok && !full;
		ctrl.wr_type  = (state_q == S_SCAN) && (op_q == KIND_DEFINE)
			&& hit_ok && (scope_q == '0);
		ctrl.pop      = (state_q == S_POP) && (count_q != '0)
			&& (depth_a[0] == scope_q);
	end

	// Row of entry cells; the first cell takes pushes from the query registers
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		logic [KEY_W-1:0]   up_key;
		logic [LEN_W-1:0]   up_len;
		logic [TYPE_W-1:0]  up_typ;
		logic [DEPTH_W-1:0] up_depth;
		logic [KEY_W-1:0]   dn_key;
		logic [LEN_W-1:0]   dn_len;
		logic [TYPE_W-1:0]  dn_typ;
		logic [DEPTH_W-1:0] dn_depth;
		logic               tok_in;

		if (g == 0) begin : g_head
			assign up_key   = qkey_q;
			assign up_len   = qlen_q;
			assign up_typ   = qtype_q;
			assign up_depth = scope_q;
			assign tok_in   = start;
		end else begin : g_body
			assign up_key   = key_a[g-1];
			assign up_len   = len_a[g-1];
			assign up_typ   = typ_a[g-1];
			assign up_depth = depth_a[g-1];
			assign tok_in   = tok_v[g-1];
		end

		if (g == ENTRIES - 1) begin : g_tail
			assign dn_key   = qkey_q;
			assign dn_len   = qlen_q;
			assign dn_typ   = qtype_q;
			assign dn_depth = scope_q;
		end else begin : g_inner
			assign dn_key   = key_a[g+1];
			assign dn_len   = len_a[g+1];
			assign dn_typ   = typ_a[g+1];
			assign dn_depth = depth_a[g+1];
		end

		sst_cell #(
			.KEY_W (KEY_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl),
			.q_key    (qkey_q),
			.tok_in   (tok_in),
			.up_key   (up_key),
			.up_len   (up_len),
			.up_typ   (up_typ),
			.up_depth (up_depth),
			.dn_key   (dn_key),
			.dn_len   (dn_len),
			.dn_typ   (dn_typ),
			.dn_depth (dn_depth),
			.tok      (tok_v[g]),
			.key      (key_a[g]),
			.len      (len_a[g]),
			.typ      (typ_a[g]),
			.depth    (depth_a[g]),
			.hit      (hit_v[g]),
			.stop     (stop_v[g]),
			.hit_typ  (htyp_a[g])
		);
	end

	// Query registers: no reset needed
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && req_valid) begin
			op_q    <= kind;
			qkey_q  <= name_key[KEY_W-1:0];
			qlen_q  <= ident_len;
			qtype_q <= type_code;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			remain_q     <= '0;
			scope_q      <= '0;
			res_status_q <= STATUS_OK;
			res_type_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						res_status_q <= STATUS_OK;
						res_type_q   <= '0;
						unique case (kind)
							KIND_DEFINE, KIND_LOOKUP: begin
								remain_q <= count_q;
								state_q  <= S_SCAN;
							end
							KIND_ENTER: begin
								if (scope_q != SCOPE_MAX) begin
									scope_q <= scope_q + 1'b1;
								end
								state_q <= S_DONE;
							end
							KIND_EXIT: begin
								state_q <= S_POP;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						state_q <= S_DONE;
						if (op_q == KIND_LOOKUP) begin
							res_status_q <= hit_ok ? STATUS_OK : STATUS_NOT_FOUND;
							res_type_q   <= hit_ok ? hit_type : '0;
						end else if (hit_ok) begin
							res_status_q <= (scope_q == '0) ? STATUS_OK : STATUS_REDEF;
						end else if (full) begin
							res_status_q <= STATUS_FULL;
						end else begin
							res_status_q <= STATUS_OK;
							count_q      <= count_q + 1'b1;
						end
					end else begin
						remain_q <= remain_q - 1'b1;
					end
				end
				S_POP: begin
					if (ctrl.pop) begin
						count_q <= count_q - 1'b1;
					end else begin
						if (scope_q != '0) begin
							scope_q <= scope_q - 1'b1;
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: load when free, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && rsp_free) begin
			status_q   <= res_status_q;
			type_out_q <= res_type_q;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign status    = status_q;
	assign type_out  = type_out_q;

endmodule
